// ===== hdl/q2e_pkg.sv =====
// Shared constants, types and helpers for the quaternion to Euler angle unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package q2e_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF     = 16;

  // lock threshold register, Q1.30
  localparam int              THR_W     = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1073634450;

  // normalizer and CORDIC datapath
  localparam int NORM_W       = 64;
  localparam int NORM_STAGES  = 6;
  localparam int CORD_IN_W    = 41;
  localparam int CORD_W       = 45;
  localparam int CORDIC_STEPS = 30;
  localparam int TURN_W       = 34;   // angle in 2^-32 turn, signed
  localparam int TURN_FRAC    = 32;
  localparam int AT_LAT       = 1 + NORM_STAGES + CORDIC_STEPS + 1;

  // square root chain for cos(pitch)
  localparam int SQ_W      = 62;
  localparam int SQ_STAGES = 31;
  localparam int S30_W     = 32;
  localparam int M_W       = 31;

  typedef logic signed [TURN_W-1:0] turn_t;

  localparam turn_t ATAN_TAB [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
    34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
    34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
  };

  // quadrant info that rides along the atan2 pipeline
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } at2_flags_t;

  // round to nearest (half up) from 2^-32 turn, dropping sh bits
  function automatic turn_t round_turn(input turn_t t, input int sh);
    turn_t half;
    half = turn_t'(1) <<< (sh - 1);
    return (t + half) >>> sh;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/quaternion_to_euler_angles_unit.sv =====
// Quaternion to Euler angle converter: takes one quaternion per cycle and returns
// yaw, pitch and roll as binary angles with a gimbal lock flag. The pipeline holds
// 3 front stages, a 31-cell square root chain for cos(pitch), 38 atan2 stages
// with 30 CORDIC cells and one output register. It accepts a new
// transfer every cycle unless a finished result is waiting under out_stall; only
// then does the whole pipeline freeze, with in_stall raised for those cycles.
// The lock threshold register is written through cfg_*, which is always ready;
// write it only while the unit holds no transfer in flight.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_atan2.
`default_nettype none
module quaternion_to_euler_angles_unit import q2e_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [COMPONENT_BITS-1:0] in_quat_x,
  input  wire logic signed [COMPONENT_BITS-1:0] in_quat_y,
  input  wire logic signed [COMPONENT_BITS-1:0] in_quat_z,
  input  wire logic signed [COMPONENT_BITS-1:0] in_quat_w,
  input  wire logic                             in_use_inverse,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed      [ANGLE_BITS-1:0]     out_yaw_angle,
  output logic signed      [ANGLE_BITS-1:0]     out_pitch_angle,
  output logic signed      [ANGLE_BITS-1:0]     out_roll_angle,
  output logic                                  out_gimbal_lock,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic        [THR_W-1:0]          cfg_lock_threshold
);

  localparam int P   = 2 * (COMPONENT_BITS - 2);
  localparam int D   = P - 30;
  localparam int DP  = (D > 0) ? D : 0;
  localparam int DN  = (D < 0) ? -D : 0;
  localparam int PW  = 2 * COMPONENT_BITS;
  localparam int AW  = (PW + 2 > S30_W) ? PW + 2 : S30_W;
  localparam int LW  = (AW + DN > THR_W + DP) ? AW + DN : THR_W + DP;
  localparam int SH  = TURN_FRAC - ANGLE_BITS;
  localparam int LAT = 3 + SQ_STAGES + AT_LAT + 1;

  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (P - 1);
  localparam logic        [AW-1:0] ONE  = AW'(1) << P;
  localparam logic        [SQ_W-1:0] SQ_ONE = SQ_W'(1) << (2 * M_W - 2);

  logic             adv;
  logic [LAT-1:0]   vld_r;
  logic [THR_W-1:0] thr_r;

  // stage 1: products
  logic signed [PW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic                 inv_r;

  // stage 2: sine of pitch, lock, atan2 arguments
  logic signed [AW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [AW-1:0] spt, sp, yy_arg, yx_arg, ry_arg, rx_arg;
  logic        [AW-1:0] asp, asp_c;
  logic        [M_W-1:0] m;
  logic signed [S30_W-1:0] m_s, s30;
  logic                 lock;
  logic                 lock2_r;
  logic        [M_W-1:0] m2_r;
  logic signed [S30_W-1:0] s30_2_r;
  logic signed [AW-1:0] yy2_r, yx2_r, ry2_r, rx2_r;

  // stage 3 and square root chain
  logic [SQ_W-1:0] mm_r;
  logic [SQ_W-1:0] n_s [SQ_STAGES+1];
  logic [SQ_W-1:0] r_s [SQ_STAGES+1];

  // side line alongside the square root chain
  logic                    sd_lock [SQ_STAGES+1];
  logic signed [S30_W-1:0] sd_s30  [SQ_STAGES+1];
  logic signed [AW-1:0]    sd_yy   [SQ_STAGES+1];
  logic signed [AW-1:0]    sd_yx   [SQ_STAGES+1];
  logic signed [AW-1:0]    sd_ry   [SQ_STAGES+1];
  logic signed [AW-1:0]    sd_rx   [SQ_STAGES+1];

  // side line alongside the atan2 units
  logic                    ld_lock [AT_LAT];
  logic signed [S30_W-1:0] ld_s30  [AT_LAT];

  logic signed [AW-1:0] px, py;
  turn_t                t_yaw, t_pitch, t_roll;
  turn_t                ry, rp, rr, rl;

  logic signed [ANGLE_BITS-1:0] yaw_r, pitch_r, roll_r;
  logic                         glock_r;

  // handshake: whole pipeline moves unless a finished result is held
  assign adv       = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= THR_RESET;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_lock_threshold;
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r  <= PW'(in_quat_x) * PW'(in_quat_x);
      yy_r  <= PW'(in_quat_y) * PW'(in_quat_y);
      zz_r  <= PW'(in_quat_z) * PW'(in_quat_z);
      xy_r  <= PW'(in_quat_x) * PW'(in_quat_y);
      xz_r  <= PW'(in_quat_x) * PW'(in_quat_z);
      yz_r  <= PW'(in_quat_y) * PW'(in_quat_z);
      wx_r  <= PW'(in_quat_w) * PW'(in_quat_x);
      wy_r  <= PW'(in_quat_w) * PW'(in_quat_y);
      wz_r  <= PW'(in_quat_w) * PW'(in_quat_z);
      inv_r <= in_use_inverse;
    end
  end

  // stage 2
  assign xx = AW'(xx_r);
  assign yy = AW'(yy_r);
  assign zz = AW'(zz_r);
  assign xy = AW'(xy_r);
  assign xz = AW'(xz_r);
  assign yz = AW'(yz_r);
  assign wx = AW'(wx_r);
  assign wy = AW'(wy_r);
  assign wz = AW'(wz_r);

  assign spt   = inv_r ? (yz + wx) : (yz - wx);
  assign sp    = -(spt <<< 1);
  assign asp   = sp[AW-1] ? AW'(-sp) : AW'(sp);
  assign lock  = (LW'(asp) << DN) > (LW'(thr_r) << DP);
  assign asp_c = (asp > ONE) ? ONE : asp;

  // bring |sp| to Q1.30
  if (D > 0) begin : g_m_down
    logic [AW-1:0] rnd;
    assign rnd = (asp_c + (AW'(1) << (D - 1))) >> D;
    assign m   = rnd[M_W-1:0];
  end else if (D == 0) begin : g_m_same
    assign m = asp_c[M_W-1:0];
  end else begin : g_m_up
    logic [AW+DN-1:0] up;
    assign up = (AW+DN)'(asp_c) << DN;
    assign m  = up[M_W-1:0];
  end

  assign m_s = S30_W'(m);
  assign s30 = sp[AW-1] ? -m_s : m_s;

  always_comb begin
    if (lock) begin
      yy_arg = inv_r ? -(xz + wy) : (wy - xz);
      yx_arg = HALF - yy - zz;
    end else begin
      yy_arg = inv_r ? (xz - wy) : (xz + wy);
      yx_arg = HALF - xx - yy;
    end
    ry_arg = inv_r ? (xy - wz) : (xy + wz);
    rx_arg = HALF - xx - zz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lock2_r <= lock;
      m2_r    <= m;
      s30_2_r <= s30;
      yy2_r   <= yy_arg;
      yx2_r   <= yx_arg;
      ry2_r   <= ry_arg;
      rx2_r   <= rx_arg;
    end
  end

  // stage 3: square of sin(pitch), start of side line
  always_ff @(posedge clk) begin
    if (adv) begin
      mm_r       <= SQ_W'(m2_r) * SQ_W'(m2_r);
      sd_lock[0] <= lock2_r;
      sd_s30[0]  <= s30_2_r;
      sd_yy[0]   <= yy2_r;
      sd_yx[0]   <= yx2_r;
      sd_ry[0]   <= ry2_r;
      sd_rx[0]   <= rx2_r;
    end
  end

  // cos(pitch) = isqrt(2^60 - m^2)
  assign n_s[0] = SQ_ONE - mm_r;
  assign r_s[0] = '0;
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    q2e_sqrt_cell #(.BITPOS(2 * (SQ_STAGES - 1 - k))) u_sqrt (
      .clk(clk), .en(adv),
      .n_in(n_s[k]), .r_in(r_s[k]),
      .n_out(n_s[k+1]), .r_out(r_s[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        sd_lock[k+1] <= sd_lock[k];
        sd_s30[k+1]  <= sd_s30[k];
        sd_yy[k+1]   <= sd_yy[k];
        sd_yx[k+1]   <= sd_yx[k];
        sd_ry[k+1]   <= sd_ry[k];
        sd_rx[k+1]   <= sd_rx[k];
      end
    end
  end

  // three atan2 pipelines
  assign py = AW'(sd_s30[SQ_STAGES]);
  assign px = AW'(r_s[SQ_STAGES][M_W-1:0]);

  q2e_atan2 #(.AW(AW)) u_at_yaw (
    .clk(clk), .en(adv),
    .y_in(sd_yy[SQ_STAGES]), .x_in(sd_yx[SQ_STAGES]), .t_out(t_yaw)
  );
  q2e_atan2 #(.AW(AW)) u_at_pitch (
    .clk(clk), .en(adv), .y_in(py), .x_in(px), .t_out(t_pitch)
  );
  q2e_atan2 #(.AW(AW)) u_at_roll (
    .clk(clk), .en(adv),
    .y_in(sd_ry[SQ_STAGES]), .x_in(sd_rx[SQ_STAGES]), .t_out(t_roll)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_lock[0] <= sd_lock[SQ_STAGES];
      ld_s30[0]  <= sd_s30[SQ_STAGES];
      for (int k = 1; k < AT_LAT; k++) begin
        ld_lock[k] <= ld_lock[k-1];
        ld_s30[k]  <= ld_s30[k-1];
      end
    end
  end

  // rounding and output register
  assign ry = round_turn(t_yaw, SH);
  assign rp = round_turn(t_pitch, SH);
  assign rr = round_turn(t_roll, SH);
  assign rl = round_turn(TURN_W'(ld_s30[AT_LAT-1]), SH);

  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_r   <= ry[ANGLE_BITS-1:0];
      pitch_r <= ld_lock[AT_LAT-1] ? rl[ANGLE_BITS-1:0] : rp[ANGLE_BITS-1:0];
      roll_r  <= ld_lock[AT_LAT-1] ? '0 : rr[ANGLE_BITS-1:0];
      glock_r <= ld_lock[AT_LAT-1];
    end
  end

  assign out_yaw_angle   = yaw_r;
  assign out_pitch_angle = pitch_r;
  assign out_roll_angle  = roll_r;
  assign out_gimbal_lock = glock_r;

endmodule
`default_nettype wire

// ===== hdl/q2e_norm_cell.sv =====
// One binary stage of the leading-one normalizer in front of the CORDIC.
// Depends on q2e_pkg.
`default_nettype none
module q2e_norm_cell import q2e_pkg::*; #(
  parameter int SHIFT = 1
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NORM_W-1:0] ax_in,
  input  wire logic [NORM_W-1:0] ay_in,
  input  wire at2_flags_t        flags_in,
  output logic      [NORM_W-1:0] ax_out,
  output logic      [NORM_W-1:0] ay_out,
  output at2_flags_t             flags_out
);

  logic [NORM_W-1:0] lead;
  logic [NORM_W-1:0] ax_r, ay_r, ax_nxt, ay_nxt;
  at2_flags_t        flags_r;

  // shift both when the top SHIFT bits of the larger are clear
  assign lead = ax_in | ay_in;
  always_comb begin
    if (lead[NORM_W-1 -: SHIFT] == '0) begin
      ax_nxt = ax_in << SHIFT;
      ay_nxt = ay_in << SHIFT;
    end else begin
      ax_nxt = ax_in;
      ay_nxt = ay_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      flags_r <= flags_in;
    end
  end

  assign ax_out    = ax_r;
  assign ay_out    = ay_r;
  assign flags_out = flags_r;

endmodule
`default_nettype wire

// ===== hdl/q2e_cordic_cell.sv =====
// One CORDIC vectoring step with its fixed arctangent constant.
// Depends on q2e_pkg.
`default_nettype none
module q2e_cordic_cell import q2e_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [CORD_W-1:0] cx_in,
  input  wire logic signed [CORD_W-1:0] cy_in,
  input  wire turn_t                    t_in,
  input  wire at2_flags_t               flags_in,
  output logic signed      [CORD_W-1:0] cx_out,
  output logic signed      [CORD_W-1:0] cy_out,
  output turn_t                         t_out,
  output at2_flags_t                    flags_out
);

  logic signed [CORD_W-1:0] dx, dy, cx_r, cy_r, cx_nxt, cy_nxt;
  turn_t                    t_r, t_nxt;
  at2_flags_t               flags_r;

  // rotate toward the x axis
  assign dx = cy_in >>> STEP;
  assign dy = cx_in >>> STEP;
  always_comb begin
    if (cy_in > 0) begin
      cx_nxt = cx_in + dx;
      cy_nxt = cy_in - dy;
      t_nxt  = t_in + ATAN_TAB[STEP];
    end else begin
      cx_nxt = cx_in - dx;
      cy_nxt = cy_in + dy;
      t_nxt  = t_in - ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      t_r     <= t_nxt;
      flags_r <= flags_in;
    end
  end

  assign cx_out    = cx_r;
  assign cy_out    = cy_r;
  assign t_out     = t_r;
  assign flags_out = flags_r;

endmodule
`default_nettype wire

// ===== hdl/q2e_sqrt_cell.sv =====
// One digit step of the restoring integer square root (floor).
// Depends on q2e_pkg.
`default_nettype none
module q2e_sqrt_cell import q2e_pkg::*; #(
  parameter int BITPOS = 0
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [SQ_W-1:0] n_in,
  input  wire logic [SQ_W-1:0] r_in,
  output logic      [SQ_W-1:0] n_out,
  output logic      [SQ_W-1:0] r_out
);

  localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << BITPOS;

  logic [SQ_W-1:0] trial, n_r, r_r, n_nxt, r_nxt;

  // subtract r + bit when it fits
  assign trial = r_in + BITV;
  always_comb begin
    if (n_in >= trial) begin
      n_nxt = n_in - trial;
      r_nxt = (r_in >> 1) + BITV;
    end else begin
      n_nxt = n_in;
      r_nxt = r_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      r_r <= r_nxt;
    end
  end

  assign n_out = n_r;
  assign r_out = r_r;

endmodule
`default_nettype wire

// ===== hdl/q2e_atan2.sv =====
// Pipelined atan2: magnitude stage, normalizer cells, CORDIC cells, quadrant fix.
// Depends on q2e_pkg, q2e_norm_cell and q2e_cordic_cell.
`default_nettype none
module q2e_atan2 import q2e_pkg::*; #(
  parameter int AW = 34
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] y_in,
  input  wire logic signed [AW-1:0] x_in,
  output turn_t                     t_out
);

  localparam turn_t HALF_TURN = turn_t'(1) <<< (TURN_FRAC - 1);

  logic [AW-1:0]     ax, ay;
  logic [NORM_W-1:0] ax_s [NORM_STAGES+1];
  logic [NORM_W-1:0] ay_s [NORM_STAGES+1];
  at2_flags_t        nf_s [NORM_STAGES+1];

  logic signed [CORD_W-1:0] cx_s [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] cy_s [CORDIC_STEPS+1];
  turn_t                    t_s  [CORDIC_STEPS+1];
  at2_flags_t               cf_s [CORDIC_STEPS+1];

  turn_t      t_r, t_nxt, tc;
  at2_flags_t fl;

  // magnitudes and signs
  assign ax = x_in[AW-1] ? AW'(-x_in) : AW'(x_in);
  assign ay = y_in[AW-1] ? AW'(-y_in) : AW'(y_in);
  always_ff @(posedge clk) begin
    if (en) begin
      ax_s[0]      <= NORM_W'(ax);
      ay_s[0]      <= NORM_W'(ay);
      nf_s[0].xneg <= x_in[AW-1];
      nf_s[0].yneg <= y_in[AW-1];
      nf_s[0].zero <= (ax == '0) && (ay == '0);
    end
  end

  // leading one to the top bit, 32/16/8/4/2/1
  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    q2e_norm_cell #(.SHIFT(1 << (NORM_STAGES - 1 - k))) u_norm (
      .clk(clk), .en(en),
      .ax_in(ax_s[k]), .ay_in(ay_s[k]), .flags_in(nf_s[k]),
      .ax_out(ax_s[k+1]), .ay_out(ay_s[k+1]), .flags_out(nf_s[k+1])
    );
  end

  // top bits give the larger value in [2^40, 2^41)
  assign cx_s[0] = CORD_W'(ax_s[NORM_STAGES][NORM_W-1 -: CORD_IN_W]);
  assign cy_s[0] = CORD_W'(ay_s[NORM_STAGES][NORM_W-1 -: CORD_IN_W]);
  assign t_s[0]  = '0;
  assign cf_s[0] = nf_s[NORM_STAGES];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    q2e_cordic_cell #(.STEP(i)) u_cordic (
      .clk(clk), .en(en),
      .cx_in(cx_s[i]), .cy_in(cy_s[i]), .t_in(t_s[i]), .flags_in(cf_s[i]),
      .cx_out(cx_s[i+1]), .cy_out(cy_s[i+1]), .t_out(t_s[i+1]), .flags_out(cf_s[i+1])
    );
  end

  // place the first-quadrant angle by the signs of x and y
  assign tc = t_s[CORDIC_STEPS];
  assign fl = cf_s[CORDIC_STEPS];
  always_comb begin
    if (fl.zero) begin
      t_nxt = '0;
    end else if (!fl.xneg) begin
      t_nxt = fl.yneg ? -tc : tc;
    end else begin
      t_nxt = fl.yneg ? tc - HALF_TURN : HALF_TURN - tc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

  assign t_out = t_r;

endmodule
`default_nettype wire
